// File: rtl/crre_pkg.sv
// crre_pkg: shared constants, widths and types of the curvature relative rms error core
// no dependencies
package crre_pkg;
  localparam int FracBits    = 16;
  localparam int CurvW       = 24;
  localparam int TolW        = 23;
  localparam int SumW        = 60;
  localparam int CountW      = 13;
  localparam int MaxNodes    = 4096;
  localparam int TotalW      = 42;
  localparam int SubCountW   = 11;
  localparam int MaxSubs     = 1024;
  localparam int IndexW      = 10;
  localparam int OutW        = 32;
  localparam int DvdW        = SumW + 2 * FracBits;
  localparam int RootW       = DvdW / 2;
  localparam int SqRemW      = RootW + 3;
  localparam int StepW       = 7;

  typedef struct packed {
    logic [SumW-1:0]   diff_sum;
    logic [SumW-1:0]   curv_sum;
    logic [CountW-1:0] nodes;
    logic              mesh_end;
  } job_t;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_DIV  = 7'b0000010,
    S_SQRT = 7'b0000100,
    S_NDIV = 7'b0001000,
    S_ACC  = 7'b0010000,
    S_MEAN = 7'b0100000,
    S_OUT  = 7'b1000000
  } back_state_t;
endpackage

// File: rtl/curvature_relative_rms_error_core.sv
// curvature_relative_rms_error_core: top level, front accumulator, job queue and back unit
// depends on crre_pkg, crre_front, crre_fifo, crre_back
// path: a node passes the a and b stage registers before the sums; a submesh result follows 92
// divide, 46 root and 46 node divide steps (none if a sum is 0), plus a mean divide at mesh end
// flow: one node per cycle unless a submesh end meets a full queue; back takes jobs only when idle
// reset: synchronous, clears sums, counts and queues; tolerance returns to 66
module curvature_relative_rms_error_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic signed [crre_pkg::CurvW-1:0] gauss_analytic,
  input  logic signed [crre_pkg::CurvW-1:0] gauss_discrete,
  input  logic signed [crre_pkg::CurvW-1:0] mean_analytic,
  input  logic signed [crre_pkg::CurvW-1:0] mean_discrete,
  input  logic                              last_of_submesh,
  input  logic                              last_of_mesh,
  output logic                              empty,
  input  logic                              pop,
  output logic [crre_pkg::OutW-1:0]         submesh_error,
  output logic [crre_pkg::OutW-1:0]         mesh_error,
  output logic                              mesh_done,
  output logic [crre_pkg::IndexW-1:0]       submesh_number,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [crre_pkg::TolW-1:0]         cfg_data
);
  import crre_pkg::*;

  logic [TolW-1:0] curvature_tolerance;
  logic            job_push, job_full, job_valid, job_pop;
  job_t            job_in, job_out;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) curvature_tolerance <= TolW'(66);
    else if (cfg_valid && cfg_ready) curvature_tolerance <= cfg_data;
  end

  crre_front u_front (
    .clk, .rst, .push, .full,
    .gauss_analytic, .gauss_discrete, .mean_analytic, .mean_discrete,
    .last_of_submesh, .last_of_mesh,
    .tolerance(curvature_tolerance),
    .job_full, .job_push, .job(job_in)
  );

  crre_fifo u_fifo (
    .clk, .rst,
    .wr(job_push), .wdata(job_in), .wfull(job_full),
    .rd(job_pop), .rvalid(job_valid), .rdata(job_out)
  );

  crre_back u_back (
    .clk, .rst, .job_valid, .job(job_out), .job_pop,
    .empty, .pop, .submesh_error, .mesh_error, .mesh_done, .submesh_number
  );

  a_no_overfill: assert property (@(posedge clk) disable iff (rst) job_full |-> !job_push)
    else $error("job written into full queue");
  a_pop_has_job: assert property (@(posedge clk) disable iff (rst) job_pop |-> job_valid)
    else $error("job taken from empty queue");
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result present after reset");
endmodule

// File: rtl/crre_front.sv
// crre_front: accepts nodes, classifies them, squares and accumulates per submesh
// depends on crre_pkg
module crre_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic signed [crre_pkg::CurvW-1:0] gauss_analytic,
  input  logic signed [crre_pkg::CurvW-1:0] gauss_discrete,
  input  logic signed [crre_pkg::CurvW-1:0] mean_analytic,
  input  logic signed [crre_pkg::CurvW-1:0] mean_discrete,
  input  logic                              last_of_submesh,
  input  logic                              last_of_mesh,
  input  logic [crre_pkg::TolW-1:0]         tolerance,
  input  logic                              job_full,
  output logic                              job_push,
  output crre_pkg::job_t                    job
);
  import crre_pkg::*;

  logic                 adv;
  logic                 a_valid, a_use, a_end, a_mesh;
  logic [CurvW:0]       a_df;
  logic [CurvW-1:0]     a_an;
  logic                 b_valid, b_use, b_end, b_mesh;
  logic [2*CurvW+1:0]   b_dsq;
  logic [2*CurvW-1:0]   b_csq;
  logic [SumW-1:0]      diff_square_sum, curv_square_sum;
  logic [CountW-1:0]    node_count;
  logic [SumW-1:0]      dsum_next, csum_next;
  logic [CountW-1:0]    count_next;
  logic [SumW:0]        dadd, cadd;
  logic [CurvW-1:0]     abs_ga, abs_ha;
  logic signed [CurvW:0] gdf, hdf;
  logic [CurvW:0]       abs_gdf, abs_hdf;
  logic                 gsel, hsel;

  assign adv  = !(b_valid && b_end && job_full);
  assign full = !adv;

  always_comb begin
    abs_ga  = gauss_analytic[CurvW-1] ? CurvW'(-gauss_analytic) : CurvW'(gauss_analytic);
    abs_ha  = mean_analytic[CurvW-1] ? CurvW'(-mean_analytic) : CurvW'(mean_analytic);
    gdf     = (CurvW+1)'(gauss_discrete) - (CurvW+1)'(gauss_analytic);
    hdf     = (CurvW+1)'(mean_discrete) - (CurvW+1)'(mean_analytic);
    abs_gdf = gdf[CurvW] ? (CurvW+1)'(-gdf) : (CurvW+1)'(gdf);
    abs_hdf = hdf[CurvW] ? (CurvW+1)'(-hdf) : (CurvW+1)'(hdf);
    gsel    = {1'b0, abs_ga} >= {2'b0, tolerance};
    hsel    = {1'b0, abs_ha} >= {2'b0, tolerance};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= push;
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_use  <= gsel || hsel;
      a_df   <= gsel ? abs_gdf : abs_hdf;
      a_an   <= gsel ? abs_ga : abs_ha;
      a_end  <= last_of_submesh || last_of_mesh;
      a_mesh <= last_of_mesh;
      b_use  <= a_use;
      b_dsq  <= a_df * a_df;
      b_csq  <= a_an * a_an;
      b_end  <= a_end;
      b_mesh <= a_mesh;
    end
  end

  always_comb begin
    dadd       = {1'b0, diff_square_sum} + (SumW+1)'(b_dsq);
    cadd       = {1'b0, curv_square_sum} + (SumW+1)'(b_csq);
    dsum_next  = diff_square_sum;
    csum_next  = curv_square_sum;
    if (b_use) begin
      dsum_next = dadd[SumW] ? {SumW{1'b1}} : dadd[SumW-1:0];
      csum_next = cadd[SumW] ? {SumW{1'b1}} : cadd[SumW-1:0];
    end
    count_next = (node_count < CountW'(MaxNodes)) ? node_count + 1'b1 : node_count;
  end

  assign job_push     = b_valid && b_end && !job_full;
  assign job.diff_sum = dsum_next;
  assign job.curv_sum = csum_next;
  assign job.nodes    = count_next;
  assign job.mesh_end = b_mesh;

  always_ff @(posedge clk) begin
    if (rst) begin
      diff_square_sum <= '0;
      curv_square_sum <= '0;
      node_count      <= '0;
    end else if (adv && b_valid) begin
      if (b_end) begin
        diff_square_sum <= '0;
        curv_square_sum <= '0;
        node_count      <= '0;
      end else begin
        diff_square_sum <= dsum_next;
        curv_square_sum <= csum_next;
        node_count      <= count_next;
      end
    end
  end
endmodule

// File: rtl/crre_fifo.sv
// crre_fifo: two-entry queue of finished submesh sums between front and back
// depends on crre_pkg
module crre_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr,
  input  crre_pkg::job_t wdata,
  output logic           wfull,
  input  logic           rd,
  output logic           rvalid,
  output crre_pkg::job_t rdata
);
  import crre_pkg::*;

  job_t       slots [2];
  logic       wptr, rptr;
  logic [1:0] used;

  assign wfull  = used == 2'd2;
  assign rvalid = used != 2'd0;
  assign rdata  = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      used <= 2'd0;
    end else begin
      if (wr) wptr <= !wptr;
      if (rd) rptr <= !rptr;
      used <= used + {1'b0, wr} - {1'b0, rd};
    end
  end

  always_ff @(posedge clk) begin
    if (wr) slots[wptr] <= wdata;
  end
endmodule

// File: rtl/crre_back.sv
// crre_back: per submesh divide, square root, node division and mesh mean
// depends on crre_pkg; uses one shared restoring divider and a digit square root
module crre_back (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            job_valid,
  input  crre_pkg::job_t                  job,
  output logic                            job_pop,
  output logic                            empty,
  input  logic                            pop,
  output logic [crre_pkg::OutW-1:0]       submesh_error,
  output logic [crre_pkg::OutW-1:0]       mesh_error,
  output logic                            mesh_done,
  output logic [crre_pkg::IndexW-1:0]     submesh_number
);
  import crre_pkg::*;

  back_state_t          state;
  logic [DvdW-1:0]      dvd;
  logic [SumW:0]        rem;
  logic [SumW-1:0]      dsr;
  logic [StepW-1:0]     step;
  logic [SqRemW-1:0]    sq_rem;
  logic [RootW-1:0]     root;
  logic [CountW-1:0]    j_n;
  logic                 j_mesh;
  logic [OutW-1:0]      err, mean;
  logic [IndexW-1:0]    idx;
  logic [TotalW-1:0]    error_total;
  logic [SubCountW-1:0] submesh_count;
  logic                 ovalid;
  logic [SumW:0]        rem_sh;
  logic                 ge;
  logic [SqRemW+1:0]    sq_sh, trial;
  logic                 sq_ge;
  logic [TotalW:0]      tadd;
  logic [TotalW-1:0]    total_new;
  logic [SubCountW-1:0] count_new;
  logic [SumW-FracBits-1:0] raw;

  assign empty = !ovalid;
  assign job_pop = (state == S_IDLE) && job_valid;

  always_comb begin
    rem_sh    = {rem[SumW-1:0], dvd[DvdW-1]};
    ge        = rem_sh >= {1'b0, dsr};
    sq_sh     = {sq_rem, dvd[DvdW-1:DvdW-2]};
    trial     = (SqRemW+2)'({root, 2'b01});
    sq_ge     = sq_sh >= trial;
    tadd      = {1'b0, error_total} + (TotalW+1)'(err);
    total_new = tadd[TotalW] ? {TotalW{1'b1}} : tadd[TotalW-1:0];
    count_new = (submesh_count < SubCountW'(MaxSubs)) ? submesh_count + 1'b1 : submesh_count;
    raw       = job.diff_sum[SumW-1:FracBits];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      error_total   <= '0;
      submesh_count <= '0;
      ovalid        <= 1'b0;
    end else begin
      if (pop && ovalid && state != S_OUT) ovalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (job_valid) begin
            j_n    <= job.nodes;
            j_mesh <= job.mesh_end;
            if (job.diff_sum == '0 || job.curv_sum == '0) begin
              err   <= (raw > (SumW-FracBits)'({OutW{1'b1}})) ? {OutW{1'b1}} : OutW'(raw);
              state <= S_ACC;
            end else begin
              dvd   <= {job.diff_sum, {(2*FracBits){1'b0}}};
              dsr   <= job.curv_sum;
              rem   <= '0;
              step  <= StepW'(DvdW - 1);
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          rem  <= ge ? rem_sh - {1'b0, dsr} : rem_sh;
          dvd  <= {dvd[DvdW-2:0], ge};
          if (step == '0) begin
            sq_rem <= '0;
            root   <= '0;
            step   <= StepW'(RootW - 1);
            state  <= S_SQRT;
          end else begin
            step <= step - 1'b1;
          end
        end
        S_SQRT: begin
          sq_rem <= sq_ge ? SqRemW'(sq_sh - trial) : SqRemW'(sq_sh);
          root   <= {root[RootW-2:0], sq_ge};
          if (step == '0) begin
            dvd   <= {root[RootW-2:0], sq_ge, {(DvdW-RootW){1'b0}}};
            dsr   <= (j_n == '0) ? SumW'(1) : SumW'(j_n);
            rem   <= '0;
            step  <= StepW'(RootW - 1);
            state <= S_NDIV;
          end else begin
            dvd  <= {dvd[DvdW-3:0], 2'b00};
            step <= step - 1'b1;
          end
        end
        S_NDIV: begin
          rem  <= ge ? rem_sh - {1'b0, dsr} : rem_sh;
          dvd  <= {dvd[DvdW-2:0], ge};
          step <= step - 1'b1;
          if (step == '0) begin
            err   <= (dvd[RootW-2:OutW-1] != '0) ? {OutW{1'b1}} : {dvd[OutW-2:0], ge};
            state <= S_ACC;
          end
        end
        S_ACC: begin
          idx  <= (submesh_count < SubCountW'(MaxSubs)) ? IndexW'(submesh_count)
                                                        : IndexW'(MaxSubs - 1);
          mean <= '0;
          if (j_mesh) begin
            dvd           <= {total_new, {(DvdW-TotalW){1'b0}}};
            dsr           <= SumW'(count_new);
            rem           <= '0;
            step          <= StepW'(TotalW - 1);
            error_total   <= '0;
            submesh_count <= '0;
            state         <= S_MEAN;
          end else begin
            error_total   <= total_new;
            submesh_count <= count_new;
            state         <= S_OUT;
          end
        end
        S_MEAN: begin
          rem  <= ge ? rem_sh - {1'b0, dsr} : rem_sh;
          dvd  <= {dvd[DvdW-2:0], ge};
          step <= step - 1'b1;
          if (step == '0) begin
            mean  <= (dvd[TotalW-2:OutW-1] != '0) ? {OutW{1'b1}} : {dvd[OutW-2:0], ge};
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!ovalid || pop) begin
            submesh_error  <= err;
            mesh_error     <= mean;
            mesh_done      <= j_mesh;
            submesh_number <= idx;
            ovalid         <= 1'b1;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
